@@ hdl/ucrc_pkg.sv @@
package ucrc_pkg;

    // One input word: a byte of the text and the end-of-text mark.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_last;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       run_last;
        logic       text_end;
    } t_out_word;

    // Work handed from the front to the back: the results caused by one input word.
    typedef struct packed {
        logic [2:0][7:0] bytes;    // entry 0 goes out first
        logic [1:0]      cnt;      // number of result words, 1 to 3
        logic            present;  // 0 for an end marker without data
        logic            text_end; // last word of the job closes the text
    } t_job;

    localparam logic [7:0] CJK_LO       = 8'hE4;
    localparam logic [7:0] CJK_HI       = 8'hE9;
    localparam logic [7:0] MASK_LEAD2   = 8'hE0;
    localparam logic [7:0] CODE_LEAD2   = 8'hC0;
    localparam logic [7:0] MASK_LEAD3   = 8'hF0;
    localparam logic [7:0] CODE_LEAD3   = 8'hE0;
    localparam logic [7:0] MASK_LEAD4   = 8'hF8;
    localparam logic [7:0] CODE_LEAD4   = 8'hF0;

    // Continuation bytes that follow a lead byte outside the held CJK range.
    function automatic logic [1:0] cont_count(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            n = 2'd1;
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            n = 2'd2;
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
            n = 2'd3;
        end
        return n;
    endfunction

endpackage

@@ hdl/ucrc_front.sv @@
module ucrc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ucrc_pkg::t_in_word i_word,
    output logic              o_job_valid,
    output ucrc_pkg::t_job    o_job
);

    logic [15:0] r_held_bytes, n_held_bytes;
    logic [1:0]  r_held_count, n_held_count;
    logic [1:0]  r_pass_rem,   n_pass_rem;
    logic [23:0] r_prev_cjk,   n_prev_cjk;
    logic        r_prev_valid, n_prev_valid;

    logic [7:0]  b;
    logic        last;
    logic [23:0] cur;

    assign b    = i_word.in_byte;
    assign last = i_word.text_last;
    assign cur  = {r_held_bytes, b};

    always_comb begin
        n_held_bytes = r_held_bytes;
        n_held_count = r_held_count;
        n_pass_rem   = r_pass_rem;
        n_prev_cjk   = r_prev_cjk;
        n_prev_valid = r_prev_valid;
        o_job_valid  = 1'b0;
        o_job        = '0;
        o_job.present  = 1'b1;
        o_job.text_end = last;

        priority if (r_held_count >= 2'd2) begin
            // Third byte of a held CJK character: emit it unless it repeats.
            if (!r_prev_valid || cur != r_prev_cjk) begin
                o_job_valid    = 1'b1;
                o_job.bytes[0] = r_held_bytes[15:8];
                o_job.bytes[1] = r_held_bytes[7:0];
                o_job.bytes[2] = b;
                o_job.cnt      = 2'd3;
                n_prev_cjk     = cur;
                n_prev_valid   = 1'b1;
            end
            n_held_bytes = '0;
            n_held_count = 2'd0;
        end else if (r_held_count == 2'd1) begin
            if (last) begin
                o_job_valid    = 1'b1;
                o_job.bytes[0] = r_held_bytes[7:0];
                o_job.bytes[1] = b;
                o_job.cnt      = 2'd2;
            end else begin
                n_held_bytes = {r_held_bytes[7:0], b};
                n_held_count = 2'd2;
            end
        end else if (r_pass_rem != 2'd0) begin
            o_job_valid    = 1'b1;
            o_job.bytes[0] = b;
            o_job.cnt      = 2'd1;
            n_pass_rem     = r_pass_rem - 2'd1;
        end else if (b >= ucrc_pkg::CJK_LO && b <= ucrc_pkg::CJK_HI) begin
            if (last) begin
                o_job_valid    = 1'b1;
                o_job.bytes[0] = b;
                o_job.cnt      = 2'd1;
            end else begin
                n_held_bytes = {8'h00, b};
                n_held_count = 2'd1;
            end
        end else begin
            o_job_valid    = 1'b1;
            o_job.bytes[0] = b;
            o_job.cnt      = 2'd1;
            n_prev_valid   = 1'b0;
            n_prev_cjk     = '0;
            n_pass_rem     = ucrc_pkg::cont_count(b);
        end

        if (last) begin
            n_held_bytes = '0;
            n_held_count = 2'd0;
            n_pass_rem   = 2'd0;
            n_prev_cjk   = '0;
            n_prev_valid = 1'b0;
            if (!o_job_valid) begin
                // A dropped duplicate closes the text: send a bare end marker.
                o_job_valid   = 1'b1;
                o_job.bytes   = '0;
                o_job.cnt     = 2'd1;
                o_job.present = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bytes <= '0;
            r_held_count <= 2'd0;
            r_pass_rem   <= 2'd0;
            r_prev_cjk   <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_accept) begin
            r_held_bytes <= n_held_bytes;
            r_held_count <= n_held_count;
            r_pass_rem   <= n_pass_rem;
            r_prev_cjk   <= n_prev_cjk;
            r_prev_valid <= n_prev_valid;
        end
    end

endmodule

@@ hdl/ucrc_queue.sv @@
module ucrc_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ucrc_pkg::t_job i_job,
    input  logic           i_pop,
    output ucrc_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ucrc_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers wrap at the last entry, so any DEPTH works.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ hdl/ucrc_back.sv @@
module ucrc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ucrc_pkg::t_job      i_job,
    input  logic                i_job_empty,
    output logic                o_job_pop,
    output ucrc_pkg::t_out_word o_word,
    output logic                o_empty,
    input  logic                i_pop
);

    ucrc_pkg::t_job r_job;
    logic [1:0]     r_idx;
    logic           r_busy;
    logic           last_in_job;
    logic           take;

    assign last_in_job = (r_idx == r_job.cnt - 2'd1);
    // The current job is finished or there is none: take the next one.
    assign take        = !r_busy || (i_pop && last_in_job);
    assign o_job_pop   = take && !i_job_empty;

    assign o_empty             = !r_busy;
    assign o_word.out_byte     = r_job.bytes[r_idx];
    assign o_word.byte_present = r_job.present;
    assign o_word.run_last     = last_in_job;
    assign o_word.text_end     = last_in_job && r_job.text_end;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (take) begin
            r_busy <= !i_job_empty;
            r_idx  <= 2'd0;
        end else if (i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

@@ hdl/utf8_cjk_repeat_collapse_unit.sv @@
// The job of an input word enters the queue at the accepting edge and then the back
// part's job register, from which its first result word is shown.
// Throughput: one input word per cycle while the queue is not full, and one result
// word per cycle while the reader pops; a completed CJK character goes out as three
// result words of a single job, taken from the queue as one entry.
// Reset: synchronous, active low; it empties the queue and clears the character state.
module utf8_cjk_repeat_collapse_unit #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  ucrc_pkg::t_in_word  i_in_word,
    output logic                empty,
    input  logic                pop,
    output ucrc_pkg::t_out_word o_out_word
);

    // The front part splits the byte stream into characters. It keeps the two
    // held bytes of a CJK character, the count of continuation bytes still to
    // pass, and the last emitted CJK character. Each accepted word turns into
    // at most one job: up to three bytes that go out one after another, or an end
    // marker when the text ends on a dropped duplicate.
    logic           w_accept;
    logic           w_job_valid;
    ucrc_pkg::t_job w_job;

    // Between the parts sits a short job queue. The front stalls only when it
    // is full; the back drains it job by job, one result word per cycle while popped.
    ucrc_pkg::t_job w_head;
    logic           w_q_empty;
    logic           w_q_pop;

    assign w_accept = push && !full;

    ucrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_word      (i_in_word),
        .o_job_valid (w_job_valid),
        .o_job       (w_job)
    );

    ucrc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_job_valid),
        .i_job   (w_job),
        .i_pop   (w_q_pop),
        .o_job   (w_head),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    // The back part holds the current job in a register and walks through its
    // bytes. It loads the next job in the same cycle in which the last word of
    // the current one is taken, so the output never idles while work waits.
    ucrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head),
        .i_job_empty (w_q_empty),
        .o_job_pop   (w_q_pop),
        .o_word      (o_out_word),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    // The output side comes out of reset with nothing to show.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    // Every accepted final byte of a text produces a job, so the text is always closed.
    a_end_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.text_last) |-> w_job_valid)
        else $error("final byte of a text produced no job");

    // The end of a text is always the last word of its run.
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.text_end) |-> o_out_word.run_last)
        else $error("text end on a word that is not the last of its run");

    // A word without data is only the end marker of a text, and it carries a zero byte.
    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_word.byte_present) |->
            (o_out_word.text_end && o_out_word.out_byte == 8'h00))
        else $error("malformed end marker");

endmodule
